// ----- hdl/lbmd_pkg.sv -----
// lbmd_pkg: shared constants, codes, control structs and the cordic arctangent table
// for the lidar beam motion deskew block. No dependencies.
`default_nettype none

package lbmd_pkg;

   // default parameter values
   localparam int MAX_SEG_BEAMS = 1023;
   localparam int CORDIC_STEPS  = 16;

   // field widths
   localparam int CMD_W   = 2;
   localparam int POS_W   = 32;
   localparam int HEAD_W  = 16;
   localparam int COUNT_W = 10;
   localparam int RANGE_W = 20;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // internal widths
   localparam int CW      = 40;                 // cordic x/y datapath
   localparam int ZW      = 34;                 // cordic angle accumulator
   localparam int NUM_W   = COUNT_W + 16;       // fraction dividend
   localparam int FRAC_W  = 17;                 // Q16 fraction, up to 1.0
   localparam int CNT_W   = 5;                  // shared sequence counter
   localparam int DIV_STEPS = NUM_W;
   localparam int LERP_LAST = 3;

   localparam logic [23:0] GAIN_Q24   = 24'd10188014;
   localparam int          RANGE_MAX  = 1048575;

   // commands
   localparam logic [CMD_W-1:0] CMD_START = 2'd0;
   localparam logic [CMD_W-1:0] CMD_END   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_BEAM  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_X    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_Y    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_HEAD = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RANGE = 2'd3;

   // cordic passes
   localparam logic [1:0] PASS_BEAM = 2'd0;
   localparam logic [1:0] PASS_POSE = 2'd1;
   localparam logic [1:0] PASS_VEC  = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic             accept;
      logic             div_step;
      logic             lerp_step;
      logic [1:0]       lerp_idx;
      logic             cinit;
      logic             citer;
      logic [CNT_W-1:0] step;
      logic             gain1;
      logic             gain2;
      logic [1:0]       pass;
      logic             out_load;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic no_return;
      logic out_free;
   } dp_status_type;

   // arctangent of 2^-i as a 32 bit binary angle
   function automatic logic [31:0] atan_entry(input logic [CNT_W-1:0] i);
      logic [31:0] a;
      begin
         unique case (i)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            default: a = 32'h00000000;
         endcase
         return a;
      end
   endfunction

endpackage

`default_nettype wire

// ----- hdl/lbmd_if.sv -----
// lbmd channel interfaces: request, response and register write channels
// depends on lbmd_pkg for field widths
`default_nettype none

interface lbmd_req_if;
   logic                              valid;
   logic                              ready;
   logic [lbmd_pkg::CMD_W-1:0]        cmd;
   logic signed [lbmd_pkg::POS_W-1:0] pose_x;
   logic signed [lbmd_pkg::POS_W-1:0] pose_y;
   logic signed [lbmd_pkg::HEAD_W-1:0] pose_heading;
   logic [lbmd_pkg::COUNT_W-1:0]      seg_beam_count;
   logic [lbmd_pkg::RANGE_W-1:0]      beam_range;
   logic signed [lbmd_pkg::HEAD_W-1:0] beam_angle;
   modport source(output valid, cmd, pose_x, pose_y, pose_heading, seg_beam_count,
                  beam_range, beam_angle, input ready);
   modport sink(input valid, cmd, pose_x, pose_y, pose_heading, seg_beam_count,
                beam_range, beam_angle, output ready);
endinterface

interface lbmd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [lbmd_pkg::RANGE_W-1:0]       out_range;
   logic signed [lbmd_pkg::HEAD_W-1:0] out_angle;
   logic                               had_return;
   logic                               segment_end;
   modport source(output valid, out_range, out_angle, had_return, segment_end,
                  input ready);
   modport sink(input valid, out_range, out_angle, had_return, segment_end,
                output ready);
endinterface

interface lbmd_csr_if;
   logic                              valid;
   logic                              ready;
   logic [lbmd_pkg::CSR_IDX_W-1:0]    index;
   logic [lbmd_pkg::CSR_DATA_W-1:0]   data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/lbmd_ctrl.sv -----
// lbmd_ctrl: sequencer for divide, interpolate, three cordic passes and result load
// depends on lbmd_pkg
`default_nettype none

module lbmd_ctrl #(
   parameter int CORDIC_STEPS = lbmd_pkg::CORDIC_STEPS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic [lbmd_pkg::CMD_W-1:0]  req_cmd,
   output logic                             req_ready,
   input  wire lbmd_pkg::dp_status_type     status,
   output lbmd_pkg::ctl_cmd_type            ctl
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_DIV   = 8'b0000_0010,
      S_LERP  = 8'b0000_0100,
      S_CINIT = 8'b0000_1000,
      S_CITER = 8'b0001_0000,
      S_GAIN1 = 8'b0010_0000,
      S_GAIN2 = 8'b0100_0000,
      S_FIN   = 8'b1000_0000
   } state_type;

   state_type                    state_ff, state_in;
   logic [lbmd_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [1:0]                   pass_ff, pass_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      pass_in   = pass_ff;
      req_ready = 1'b0;
      ctl       = '0;
      ctl.step  = cnt_ff;
      ctl.pass  = pass_ff;
      ctl.lerp_idx = cnt_ff[1:0];
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.accept = 1'b1;
               if (req_cmd == lbmd_pkg::CMD_BEAM) begin
                  state_in = S_DIV;
                  cnt_in   = '0;
               end
            end
         end
         S_DIV: begin
            ctl.div_step = 1'b1;
            if (cnt_ff == lbmd_pkg::CNT_W'(lbmd_pkg::DIV_STEPS - 1)) begin
               state_in = S_LERP;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_LERP: begin
            ctl.lerp_step = 1'b1;
            if (cnt_ff == lbmd_pkg::CNT_W'(lbmd_pkg::LERP_LAST)) begin
               pass_in  = lbmd_pkg::PASS_BEAM;
               state_in = status.no_return ? S_FIN : S_CINIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_CINIT: begin
            ctl.cinit = 1'b1;
            cnt_in    = '0;
            state_in  = S_CITER;
         end
         S_CITER: begin
            ctl.citer = 1'b1;
            if (cnt_ff == lbmd_pkg::CNT_W'(CORDIC_STEPS - 1)) begin
               state_in = S_GAIN1;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_GAIN1: begin
            ctl.gain1 = 1'b1;
            state_in  = S_GAIN2;
         end
         S_GAIN2: begin
            ctl.gain2 = 1'b1;
            if (pass_ff == lbmd_pkg::PASS_VEC) begin
               state_in = S_FIN;
            end else begin
               pass_in  = pass_ff + 1'b1;
               state_in = S_CINIT;
            end
         end
         S_FIN: begin
            if (status.out_free) begin
               ctl.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         pass_ff  <= lbmd_pkg::PASS_BEAM;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pass_ff  <= pass_in;
      end
   end

   // a beam always starts the divide
   a_beam_starts_div: assert property (@(posedge clock) disable iff (reset)
      ctl.accept && req_cmd == lbmd_pkg::CMD_BEAM |=> state_ff == S_DIV)
      else $error("beam accepted without starting divide");

   // cordic step stays inside the table
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      ctl.citer |-> cnt_ff < lbmd_pkg::CNT_W'(CORDIC_STEPS))
      else $error("cordic step out of range");

   // result only loaded into a free output word
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      ctl.out_load |-> status.out_free)
      else $error("output word overwritten");

endmodule

`default_nettype wire

// ----- hdl/lbmd_dp.sv -----
// lbmd_dp: registers, segment state, fraction divider, interpolator, shared cordic,
// gain correction and output word. depends on lbmd_pkg
`default_nettype none

module lbmd_dp #(
   parameter int MAX_SEG_BEAMS = lbmd_pkg::MAX_SEG_BEAMS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire lbmd_pkg::ctl_cmd_type              ctl,
   output lbmd_pkg::dp_status_type                 status,
   input  wire logic [lbmd_pkg::CMD_W-1:0]         req_cmd,
   input  wire logic signed [lbmd_pkg::POS_W-1:0]  req_pose_x,
   input  wire logic signed [lbmd_pkg::POS_W-1:0]  req_pose_y,
   input  wire logic signed [lbmd_pkg::HEAD_W-1:0] req_pose_heading,
   input  wire logic [lbmd_pkg::COUNT_W-1:0]       req_seg_beam_count,
   input  wire logic [lbmd_pkg::RANGE_W-1:0]       req_beam_range,
   input  wire logic signed [lbmd_pkg::HEAD_W-1:0] req_beam_angle,
   input  wire logic                               csr_write,
   input  wire logic [lbmd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [lbmd_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [lbmd_pkg::RANGE_W-1:0]            rsp_out_range,
   output logic signed [lbmd_pkg::HEAD_W-1:0]      rsp_out_angle,
   output logic                                    rsp_had_return,
   output logic                                    rsp_segment_end
);

   localparam int PW = lbmd_pkg::POS_W;
   localparam int HW = lbmd_pkg::HEAD_W;
   localparam int KW = lbmd_pkg::COUNT_W;
   localparam int RW = lbmd_pkg::RANGE_W;
   localparam int CW = lbmd_pkg::CW;
   localparam int ZW = lbmd_pkg::ZW;
   localparam int NW = lbmd_pkg::NUM_W;
   localparam int FW = lbmd_pkg::FRAC_W;
   localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(64'sd1 <<< 30);
   localparam logic signed [ZW-1:0] Z_HALF    = ZW'(64'sd1 <<< 31);

   // configuration registers
   logic signed [PW-1:0] base_x_ff, base_y_ff;
   logic [HW-1:0]        base_h_ff;
   logic [RW-1:0]        min_range_ff;

   // segment state
   logic signed [PW-1:0] start_x_ff, start_y_ff, end_x_ff, end_y_ff;
   logic [HW-1:0]        start_h_ff, end_h_ff;
   logic [KW-1:0]        seg_count_ff, seg_count_in;
   logic [KW-1:0]        beam_slot_ff, beam_slot_in;

   // current beam
   logic [KW-1:0]        last_ff;
   logic                 seg_end_ff, no_ret_ff;
   logic [RW-1:0]        range_ff;
   logic [HW-1:0]        bang_ff;

   // divider, interpolator
   logic [NW-1:0]        num_ff, num_in;
   logic [KW-1:0]        rem_ff, rem_in;
   logic signed [50:0]   prod_ff, lerp_prod, lerp_rnd;
   logic signed [32:0]   lerp_diff;
   logic [FW-1:0]        frac;
   logic signed [PW-1:0] mid_x_ff, mid_y_ff;
   logic [HW-1:0]        mid_h_ff;

   // cordic
   logic signed [CW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [ZW-1:0] cz_ff, cz_in;
   logic signed [CW-1:0] lrx_ff, lry_ff, trx_ff, try_ff;
   logic signed [47:0]   ghx_ff, ghy_ff;
   logic [40:0]          glx_ff, gly_ff;
   logic signed [CW-1:0] gx, gy;

   logic                 rsp_valid_ff;
   logic [RW-1:0]        out_range_ff, out_range_in;
   logic [HW-1:0]        out_angle_ff, out_angle_in;
   logic                 had_ret_ff, seg_out_ff;

   // slot bookkeeping for a new beam
   logic [KW-1:0] last_c, slot_c, cnt_c;
   always_comb begin
      last_c = seg_count_ff - 1'b1;
      slot_c = (beam_slot_ff > last_c) ? last_c : beam_slot_ff;
      cnt_c  = req_seg_beam_count;
      if (cnt_c == '0)
         cnt_c = KW'(1);
      else if (cnt_c > KW'(MAX_SEG_BEAMS))
         cnt_c = KW'(MAX_SEG_BEAMS);
      seg_count_in = seg_count_ff;
      beam_slot_in = beam_slot_ff;
      if (ctl.accept) begin
         case (req_cmd)
            lbmd_pkg::CMD_START: beam_slot_in = '0;
            lbmd_pkg::CMD_END: begin
               seg_count_in = cnt_c;
               beam_slot_in = '0;
            end
            lbmd_pkg::CMD_BEAM: beam_slot_in = (slot_c < last_c) ? slot_c + 1'b1 : last_c;
            default: ;
         endcase
      end
   end

   // restoring divider, one quotient bit per step
   logic [KW:0] div_r, div_d;
   logic        div_ge;
   always_comb begin
      div_r  = {rem_ff, num_ff[NW-1]};
      div_ge = div_r >= {1'b0, last_ff};
      div_d  = div_r - {1'b0, last_ff};
      num_in = num_ff;
      rem_in = rem_ff;
      if (ctl.accept) begin
         num_in = {slot_c, 16'h0000} + NW'(last_c >> 1);
         rem_in = '0;
      end else if (ctl.div_step) begin
         num_in = {num_ff[NW-2:0], div_ge};
         rem_in = div_ge ? div_d[KW-1:0] : div_r[KW-1:0];
      end
   end

   // interpolation multiply and rounding
   logic [HW-1:0] dh;
   always_comb begin
      frac = (last_ff == '0) ? '0 : num_ff[FW-1:0];
      dh   = end_h_ff - start_h_ff;
      case (ctl.lerp_idx)
         2'd0:    lerp_diff = 33'(end_x_ff) - 33'(start_x_ff);
         2'd1:    lerp_diff = 33'(end_y_ff) - 33'(start_y_ff);
         default: lerp_diff = 33'($signed(dh));
      endcase
      lerp_prod = lerp_diff * $signed({1'b0, frac});
      lerp_rnd  = (prod_ff + 51'sd32768) >>> 16;
   end

   // cordic init, iteration and gain
   logic signed [CW-1:0] ix, iy, vx, vy, xs, ys;
   logic signed [ZW-1:0] z0;
   logic [HW-1:0]        ang16;
   logic                 pos;
   logic signed [ZW-1:0] at;
   logic signed [63:0]   totx, toty;
   always_comb begin
      vx = lrx_ff + trx_ff;
      vy = lry_ff + try_ff;
      if (ctl.pass == lbmd_pkg::PASS_BEAM) begin
         ix    = CW'({range_ff, 4'b0000});
         iy    = '0;
         ang16 = bang_ff + mid_h_ff - base_h_ff;
      end else begin
         ix    = CW'(mid_x_ff) - CW'(base_x_ff);
         iy    = CW'(mid_y_ff) - CW'(base_y_ff);
         ang16 = HW'(0) - base_h_ff;
      end
      z0 = ZW'($signed({ang16, 16'h0000}));
      xs = cx_ff >>> ctl.step;
      ys = cy_ff >>> ctl.step;
      at = ZW'(lbmd_pkg::atan_entry(ctl.step));
      pos = (ctl.pass == lbmd_pkg::PASS_VEC) ? cy_ff[CW-1] : !cz_ff[ZW-1];
      totx = (64'(ghx_ff) <<< 17) + $signed({23'b0, glx_ff}) + 64'sd8388608;
      toty = (64'(ghy_ff) <<< 17) + $signed({23'b0, gly_ff}) + 64'sd8388608;
      gx = CW'(totx >>> 24);
      gy = CW'(toty >>> 24);
      cx_in = cx_ff;
      cy_in = cy_ff;
      cz_in = cz_ff;
      if (ctl.cinit) begin
         if (ctl.pass == lbmd_pkg::PASS_VEC) begin
            if (vx[CW-1]) begin
               cx_in = -vx;
               cy_in = -vy;
               cz_in = Z_HALF;
            end else begin
               cx_in = vx;
               cy_in = vy;
               cz_in = '0;
            end
         end else if (z0 > Z_QUARTER) begin
            cx_in = -ix;
            cy_in = -iy;
            cz_in = z0 - Z_HALF;
         end else if (z0 < -Z_QUARTER) begin
            cx_in = -ix;
            cy_in = -iy;
            cz_in = z0 + Z_HALF;
         end else begin
            cx_in = ix;
            cy_in = iy;
            cz_in = z0;
         end
      end else if (ctl.citer) begin
         if (pos) begin
            cx_in = cx_ff - ys;
            cy_in = cy_ff + xs;
            cz_in = cz_ff - at;
         end else begin
            cx_in = cx_ff + ys;
            cy_in = cy_ff - xs;
            cz_in = cz_ff + at;
         end
      end else if (ctl.gain2) begin
         cx_in = gx;
         cy_in = gy;
      end
   end

   // final result word
   logic signed [CW-1:0] mag;
   logic [31:0]          ang_sum;
   always_comb begin
      mag     = (cx_ff + CW'(8)) >>> 4;
      ang_sum = cz_ff[31:0] + 32'd32768;
      if (no_ret_ff) begin
         out_range_in = '0;
         out_angle_in = bang_ff + mid_h_ff - start_h_ff;
      end else begin
         if (mag[CW-1])
            out_range_in = '0;
         else if (mag > CW'(lbmd_pkg::RANGE_MAX))
            out_range_in = RW'(lbmd_pkg::RANGE_MAX);
         else
            out_range_in = mag[RW-1:0];
         out_angle_in = ang_sum[31:16];
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_x_ff    <= '0;
         base_y_ff    <= '0;
         base_h_ff    <= '0;
         min_range_ff <= RW'(205);
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         start_h_ff   <= '0;
         end_x_ff     <= '0;
         end_y_ff     <= '0;
         end_h_ff     <= '0;
         seg_count_ff <= KW'(1);
         beam_slot_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               lbmd_pkg::CSR_BASE_X:    base_x_ff    <= $signed(csr_data);
               lbmd_pkg::CSR_BASE_Y:    base_y_ff    <= $signed(csr_data);
               lbmd_pkg::CSR_BASE_HEAD: base_h_ff    <= csr_data[HW-1:0];
               lbmd_pkg::CSR_MIN_RANGE: min_range_ff <= csr_data[RW-1:0];
               default: ;
            endcase
         end
         if (ctl.accept && req_cmd == lbmd_pkg::CMD_START) begin
            start_x_ff <= req_pose_x;
            start_y_ff <= req_pose_y;
            start_h_ff <= req_pose_heading;
         end
         if (ctl.accept && req_cmd == lbmd_pkg::CMD_END) begin
            end_x_ff <= req_pose_x;
            end_y_ff <= req_pose_y;
            end_h_ff <= req_pose_heading;
         end
         seg_count_ff <= seg_count_in;
         beam_slot_ff <= beam_slot_in;
         if (ctl.out_load)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      cx_ff  <= cx_in;
      cy_ff  <= cy_in;
      cz_ff  <= cz_in;
      if (ctl.accept && req_cmd == lbmd_pkg::CMD_BEAM) begin
         last_ff    <= last_c;
         seg_end_ff <= (slot_c == last_c);
         no_ret_ff  <= req_beam_range < min_range_ff;
         range_ff   <= req_beam_range;
         bang_ff    <= req_beam_angle;
      end
      if (ctl.lerp_step) begin
         prod_ff <= lerp_prod;
         case (ctl.lerp_idx)
            2'd1: mid_x_ff <= start_x_ff + lerp_rnd[PW-1:0];
            2'd2: mid_y_ff <= start_y_ff + lerp_rnd[PW-1:0];
            2'd3: mid_h_ff <= start_h_ff + lerp_rnd[HW-1:0];
            default: ;
         endcase
      end
      if (ctl.gain1) begin
         ghx_ff <= $signed(cx_ff[CW-1:17]) * $signed({1'b0, lbmd_pkg::GAIN_Q24});
         ghy_ff <= $signed(cy_ff[CW-1:17]) * $signed({1'b0, lbmd_pkg::GAIN_Q24});
         glx_ff <= cx_ff[16:0] * lbmd_pkg::GAIN_Q24;
         gly_ff <= cy_ff[16:0] * lbmd_pkg::GAIN_Q24;
      end
      if (ctl.gain2 && ctl.pass == lbmd_pkg::PASS_BEAM) begin
         lrx_ff <= gx;
         lry_ff <= gy;
      end
      if (ctl.gain2 && ctl.pass == lbmd_pkg::PASS_POSE) begin
         trx_ff <= gx;
         try_ff <= gy;
      end
      if (ctl.out_load) begin
         out_range_ff <= out_range_in;
         out_angle_ff <= out_angle_in;
         had_ret_ff   <= !no_ret_ff;
         seg_out_ff   <= seg_end_ff;
      end
   end

   assign status.no_return = no_ret_ff;
   assign status.out_free  = !rsp_valid_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_range    = out_range_ff;
   assign rsp_out_angle    = out_angle_ff;
   assign rsp_had_return   = had_ret_ff;
   assign rsp_segment_end  = seg_out_ff;

   // next slot never passes the last one
   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      ctl.accept && req_cmd == lbmd_pkg::CMD_BEAM |=> beam_slot_ff <= last_ff)
      else $error("beam slot beyond segment end");

   // beam count kept within its legal range
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      seg_count_ff != '0 && seg_count_ff <= KW'(MAX_SEG_BEAMS))
      else $error("segment count out of range");

   // a loaded result is offered next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      ctl.out_load |=> rsp_valid_ff)
      else $error("loaded result not offered");

endmodule

`default_nettype wire

// ----- hdl/lidar_beam_motion_deskew_core.sv -----
// lidar_beam_motion_deskew_core: top level, joins sequencer and datapath to the channels
// depends on lbmd_pkg, lbmd_if, lbmd_ctrl, lbmd_dp
// sequence: pose words are taken in idle; a beam with a return goes through the
//   bit-serial fraction divider, the interpolation, three passes of the single shared
//   cordic unit and the result load; a beam without one skips the cordic passes
// throughput: one word in flight; the next word is taken while a result waits in the output
// reset: synchronous, clears registers to their reset values, no clearing pass
`default_nettype none

module lidar_beam_motion_deskew_core #(
   parameter int MAX_SEG_BEAMS = lbmd_pkg::MAX_SEG_BEAMS,
   parameter int CORDIC_STEPS  = lbmd_pkg::CORDIC_STEPS
) (
   input wire logic   clock,
   input wire logic   reset,
   lbmd_req_if.sink   req_ch,
   lbmd_rsp_if.source rsp_ch,
   lbmd_csr_if.sink   csr_ch
);

   lbmd_pkg::ctl_cmd_type   ctl;
   lbmd_pkg::dp_status_type status;

   // registers always writable
   assign csr_ch.ready = 1'b1;

   lbmd_ctrl #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ch.ready),
      .status    (status),
      .ctl       (ctl)
   );

   lbmd_dp #(
      .MAX_SEG_BEAMS(MAX_SEG_BEAMS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .status             (status),
      .req_cmd            (req_ch.cmd),
      .req_pose_x         (req_ch.pose_x),
      .req_pose_y         (req_ch.pose_y),
      .req_pose_heading   (req_ch.pose_heading),
      .req_seg_beam_count (req_ch.seg_beam_count),
      .req_beam_range     (req_ch.beam_range),
      .req_beam_angle     (req_ch.beam_angle),
      .csr_write          (csr_ch.valid),
      .csr_index          (csr_ch.index),
      .csr_data           (csr_ch.data),
      .rsp_valid          (rsp_ch.valid),
      .rsp_ready          (rsp_ch.ready),
      .rsp_out_range      (rsp_ch.out_range),
      .rsp_out_angle      (rsp_ch.out_angle),
      .rsp_had_return     (rsp_ch.had_return),
      .rsp_segment_end    (rsp_ch.segment_end)
   );

endmodule

`default_nettype wire

// ----- tb/lidar_beam_motion_deskew_core_tb.sv -----
// lidar_beam_motion_deskew_core_tb: drives pose and beam words through the deskew core and
// checks every response word against a predictor of the deskew arithmetic
// depends on lbmd_pkg, lbmd_if and the core
`default_nettype none

module lidar_beam_motion_deskew_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // command code with no meaning to the core
   localparam logic [lbmd_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

   typedef struct packed {
      logic [lbmd_pkg::RANGE_W-1:0]       range;
      logic signed [lbmd_pkg::HEAD_W-1:0] angle;
      logic                               had_return;
      logic                               seg_end;
   } beam_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lbmd_req_if req_ch ();
   lbmd_rsp_if rsp_ch ();
   lbmd_csr_if csr_ch ();

   lidar_beam_motion_deskew_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   // predictor state
   longint      base_x_q, base_y_q;
   logic [15:0] base_head_q;
   logic [19:0] min_range_q;
   longint      start_x_q, start_y_q, end_x_q, end_y_q;
   logic [15:0] start_head_q, end_head_q;
   int unsigned count_q, slot_q;

   beam_result_type expected_beams[$];
   int  fail_count = 0;
   bit  quiet = 1'b0;     // no idling on either side
   logic [31:0] atan_rom[24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

   function automatic longint fl_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint gain_fix(longint v);
      return fl_shift(v * 64'sd10188014 + (64'sd1 <<< 23), 24);
   endfunction

   task automatic cordic_rotate(inout longint x, inout longint y, input logic [31:0] ang);
      longint z, nx;
      z = longint'($signed(ang));
      if (z > (64'sd1 <<< 30)) begin
         x = -x; y = -y; z -= 64'sd1 <<< 31;
      end else if (z < -(64'sd1 <<< 30)) begin
         x = -x; y = -y; z += 64'sd1 <<< 31;
      end
      for (int i = 0; i < lbmd_pkg::CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - fl_shift(y, i); y = y + fl_shift(x, i); z -= longint'(atan_rom[i]);
         end else begin
            nx = x + fl_shift(y, i); y = y - fl_shift(x, i); z += longint'(atan_rom[i]);
         end
         x = nx;
      end
      x = gain_fix(x);
      y = gain_fix(y);
   endtask

   task automatic cordic_vector(input longint x, input longint y, output longint mag,
                                output logic [31:0] ang);
      longint z, nx;
      z = 0;
      if (x < 0) begin
         x = -x; y = -y; z = 64'sd1 <<< 31;
      end
      for (int i = 0; i < lbmd_pkg::CORDIC_STEPS; i++) begin
         if (y < 0) begin
            nx = x - fl_shift(y, i); y = y + fl_shift(x, i); z -= longint'(atan_rom[i]);
         end else begin
            nx = x + fl_shift(y, i); y = y - fl_shift(x, i); z += longint'(atan_rom[i]);
         end
         x = nx;
      end
      mag = gain_fix(x);
      ang = z[31:0];
   endtask

   // predictor: update segment state, queue expected beam word
   task automatic predict_deskew(input logic [1:0] cmd, input logic [31:0] px,
                                 input logic [31:0] py, input logic [15:0] ph,
                                 input logic [9:0] cnt, input logic [19:0] rng,
                                 input logic [15:0] bang);
      int unsigned     last, slot;
      longint          frac, mid_x, mid_y, dh, lx, ly, tx, ty, mag;
      logic [15:0]     mid_h;
      logic [31:0]     vang;
      beam_result_type r;
      if (cmd == lbmd_pkg::CMD_START) begin
         start_x_q = longint'($signed(px)); start_y_q = longint'($signed(py));
         start_head_q = ph; slot_q = 0;
      end else if (cmd == lbmd_pkg::CMD_END) begin
         end_x_q = longint'($signed(px)); end_y_q = longint'($signed(py));
         end_head_q = ph;
         count_q = (cnt == 0) ? 1 : cnt;
         if (count_q > lbmd_pkg::MAX_SEG_BEAMS) count_q = lbmd_pkg::MAX_SEG_BEAMS;
         slot_q = 0;
      end else if (cmd == lbmd_pkg::CMD_BEAM) begin
         last = count_q - 1;
         slot = (slot_q > last) ? last : slot_q;
         slot_q = (slot < last) ? slot + 1 : last;
         frac = (last == 0) ? 0 : longint'(((longint'(slot) << 16) + last / 2) / last);
         mid_x = start_x_q + fl_shift((end_x_q - start_x_q) * frac + 32768, 16);
         mid_y = start_y_q + fl_shift((end_y_q - start_y_q) * frac + 32768, 16);
         dh = longint'($signed(16'(end_head_q - start_head_q)));
         mid_h = 16'(longint'(start_head_q) + fl_shift(dh * frac + 32768, 16));
         if (rng < min_range_q) begin
            r.range = '0;
            r.angle = bang + mid_h - start_head_q;
            r.had_return = 1'b0;
         end else begin
            lx = longint'(rng) << 4; ly = 0;
            cordic_rotate(lx, ly, {16'(bang + mid_h - base_head_q), 16'h0});
            tx = mid_x - base_x_q; ty = mid_y - base_y_q;
            cordic_rotate(tx, ty, {16'(16'h0 - base_head_q), 16'h0});
            cordic_vector(lx + tx, ly + ty, mag, vang);
            mag = fl_shift(mag + 8, 4);
            if (mag < 0) mag = 0;
            if (mag > lbmd_pkg::RANGE_MAX) mag = lbmd_pkg::RANGE_MAX;
            r.range = mag[19:0];
            r.angle = 16'((vang + 32'd32768) >> 16);
            r.had_return = 1'b1;
         end
         r.seg_end = (slot == last);
         expected_beams = {expected_beams, r};
      end
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // response side: random stall, check each word
   initial rsp_ch.ready = 1'b0;
   always @(posedge clock) begin
      beam_result_type w;
      rsp_ch.ready <= quiet || ($urandom_range(99) >= 18);
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_beams.size() == 0) begin
            report_mismatch("unexpected word, range", rsp_ch.out_range, -1);
         end else begin
            w = expected_beams.pop_front();
            if (rsp_ch.out_range !== w.range) report_mismatch("range", rsp_ch.out_range, w.range);
            if (rsp_ch.out_angle !== w.angle) report_mismatch("angle", rsp_ch.out_angle, w.angle);
            if (rsp_ch.had_return !== w.had_return)
               report_mismatch("had_return", rsp_ch.had_return, w.had_return);
            if (rsp_ch.segment_end !== w.seg_end)
               report_mismatch("segment_end", rsp_ch.segment_end, w.seg_end);
         end
      end
   end

   initial begin
      req_ch.valid = 1'b0; req_ch.cmd = '0; req_ch.pose_x = '0; req_ch.pose_y = '0;
      req_ch.pose_heading = '0; req_ch.seg_beam_count = '0; req_ch.beam_range = '0;
      req_ch.beam_angle = '0;
      csr_ch.valid = 1'b0; csr_ch.index = '0; csr_ch.data = '0;
   end

   // send one word, random idle before it; valid stays up until the next word or idle
   task automatic send_word(input logic [1:0] cmd, input logic [31:0] px, input logic [31:0] py,
                            input logic [15:0] ph, input logic [9:0] cnt,
                            input logic [19:0] rng, input logic [15:0] bang);
      while (!quiet && $urandom_range(99) < 18) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1; req_ch.cmd <= cmd; req_ch.pose_x <= px; req_ch.pose_y <= py;
      req_ch.pose_heading <= ph; req_ch.seg_beam_count <= cnt; req_ch.beam_range <= rng;
      req_ch.beam_angle <= bang;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_deskew(cmd, px, py, ph, cnt, rng, bang);
   endtask

   task automatic send_pose(input logic [1:0] cmd, input logic [31:0] px, input logic [31:0] py,
                            input logic [15:0] ph, input logic [9:0] cnt);
      send_word(cmd, px, py, ph, cnt, 20'($urandom), 16'($urandom));
   endtask

   task automatic send_beam(input logic [19:0] rng, input logic [15:0] bang);
      send_word(lbmd_pkg::CMD_BEAM, $urandom, $urandom, 16'($urandom), 10'($urandom),
                rng, bang);
   endtask

   // drop valid, wait for the response queue to drain, then settle
   task automatic drain;
      req_ch.valid <= 1'b0;
      while (expected_beams.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      csr_ch.valid <= 1'b1; csr_ch.index <= idx; csr_ch.data <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      case (idx)
         lbmd_pkg::CSR_BASE_X:    base_x_q = longint'($signed(value));
         lbmd_pkg::CSR_BASE_Y:    base_y_q = longint'($signed(value));
         lbmd_pkg::CSR_BASE_HEAD: base_head_q = value[15:0];
         lbmd_pkg::CSR_MIN_RANGE: min_range_q = value[19:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic random_range(output logic [19:0] r);
      case ($urandom_range(5))
         0: r = 20'($urandom_range(300));
         1: r = min_range_q + 20'($urandom_range(2)) - 20'd1;
         2: r = 20'hFFFFF - 20'($urandom_range(3));
         default: r = 20'($urandom);
      endcase
   endtask

   // extremes of the fields, each command, the open cases
   task automatic test_directed;
      send_beam(20'd1000, 16'h0);                      // beam before any segment
      send_pose(CMD_SPARE, 32'h1, 32'h1, 16'h1, 10'd5);  // unused command
      send_pose(lbmd_pkg::CMD_START, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 10'd0);
      send_pose(lbmd_pkg::CMD_END, 32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 10'd3);
      send_beam(20'hFFFFF, 16'h7FFF);
      send_beam(20'd0, 16'h8000);
      send_beam(20'd204, 16'h4000);
      send_beam(20'd205, 16'hC000);                    // slot overrun
      send_pose(lbmd_pkg::CMD_END, 32'h0, 32'h0, 16'h0, 10'd0);  // count zero
      send_beam(20'd205, 16'h0);
      send_beam(20'd100, 16'hFFFF);
      send_pose(lbmd_pkg::CMD_START, 32'h0, 32'h0, 16'h0, 10'd0);
      send_pose(lbmd_pkg::CMD_END, 32'h0, 32'h0, 16'h0, 10'd1);
      send_beam(20'd5000, 16'h0);
      send_pose(lbmd_pkg::CMD_END, 32'h0001_0000, 32'h0, 16'h2000, 10'h3FF);
      send_beam(20'd0, 16'h0);                         // zero vector possible
      send_beam(20'd4096, 16'h2000);
      send_pose(lbmd_pkg::CMD_START, 32'h0, 32'h0, 16'h4000, 10'd0);
      // shortest arc past half turn
      send_pose(lbmd_pkg::CMD_END, 32'h0, 32'h0, 16'hC001, 10'd2);
      send_beam(20'd300, 16'h0);
      send_beam(20'd300, 16'h1234);
      drain();
   endtask

   // well-formed segments with random content, some noise
   task automatic test_random(input int n_items);
      int sent = 0, cnt;
      logic [19:0] rng;
      while (sent < n_items) begin
         if ($urandom_range(9) == 0) begin
            send_pose(2'($urandom), $urandom, $urandom, 16'($urandom), 10'($urandom));
            sent++;
         end else begin
            cnt = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(1, 12);
            if ($urandom_range(7) != 0) begin
               send_pose(lbmd_pkg::CMD_START, $urandom, $urandom, 16'($urandom),
                         10'($urandom));
               sent++;
            end
            send_pose(lbmd_pkg::CMD_END, $urandom, $urandom, 16'($urandom), 10'(cnt));
            sent++;
            for (int i = 0; i < ((cnt > 20) ? 20 : cnt) + $urandom_range(2); i++) begin
               random_range(rng);
               send_beam(rng, 16'($urandom));
               sent++;
            end
         end
      end
      drain();
   endtask

   task automatic test_registers;
      write_reg(lbmd_pkg::CSR_BASE_X, 32'h8000_0000);
      write_reg(lbmd_pkg::CSR_BASE_Y, 32'h7FFF_FFFF);
      write_reg(lbmd_pkg::CSR_BASE_HEAD, 32'h0000_8000);
      write_reg(lbmd_pkg::CSR_MIN_RANGE, 32'h0);
      test_random(200);
      write_reg(lbmd_pkg::CSR_BASE_X, 32'h7FFF_FFFF);
      write_reg(lbmd_pkg::CSR_BASE_Y, 32'h8000_0000);
      write_reg(lbmd_pkg::CSR_BASE_HEAD, 32'h0000_7FFF);
      write_reg(lbmd_pkg::CSR_MIN_RANGE, 32'h000F_FFFF);
      test_random(150);
      write_reg(lbmd_pkg::CSR_BASE_X, $urandom);
      write_reg(lbmd_pkg::CSR_BASE_Y, $urandom);
      write_reg(lbmd_pkg::CSR_BASE_HEAD, $urandom);
      write_reg(lbmd_pkg::CSR_MIN_RANGE, $urandom_range(4096));
      test_random(300);
   endtask

   initial begin
      base_x_q = 0; base_y_q = 0; base_head_q = '0; min_range_q = 20'd205;
      start_x_q = 0; start_y_q = 0; end_x_q = 0; end_y_q = 0;
      start_head_q = '0; end_head_q = '0; count_q = 1; slot_q = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(600);
      quiet = 1'b1;
      test_random(200);
      quiet = 1'b0;
      test_registers();
      if (fail_count == 0 && expected_beams.size() == 0) begin
         $display("** lidar_beam_motion_deskew_core: PASSED **");
      end else begin
         $display("** lidar_beam_motion_deskew_core: FAILED **");
      end
      $finish;
   end

   // run limit
   initial begin
      #20ms;
      $display("** lidar_beam_motion_deskew_core: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
